[sv/jdjj_pkg.sv]
package jdjj_pkg;

   // drive direction codes
   localparam logic [2:0] DIR_STOP  = 3'd0;
   localparam logic [2:0] DIR_FWD   = 3'd1;
   localparam logic [2:0] DIR_BACK  = 3'd2;
   localparam logic [2:0] DIR_LEFT  = 3'd3;
   localparam logic [2:0] DIR_RIGHT = 3'd4;

   // register indexes
   localparam logic [2:0] REG_STICK_CENTER = 3'd0;
   localparam logic [2:0] REG_DEAD_ZONE    = 3'd1;
   localparam logic [2:0] REG_JOG_STEP     = 3'd2;
   localparam logic [2:0] REG_DUTY_LIMIT   = 3'd3;
   localparam logic [2:0] REG_ARM_MIN      = 3'd4;
   localparam logic [2:0] REG_ARM_MAX      = 3'd5;
   localparam logic [2:0] REG_WRIST_MAX    = 3'd6;
   localparam logic [2:0] REG_BASE_MAX     = 3'd7;

   // register reset values
   localparam logic [7:0] RST_STICK_CENTER = 8'd130;
   localparam logic [6:0] RST_DEAD_ZONE    = 7'd20;
   localparam logic [4:0] RST_JOG_STEP     = 5'd7;
   localparam logic [7:0] RST_DUTY_LIMIT   = 8'd252;
   localparam logic [7:0] RST_ARM_MIN      = 8'd45;
   localparam logic [7:0] RST_ARM_MAX      = 8'd125;
   localparam logic [7:0] RST_WRIST_MAX    = 8'd100;
   localparam logic [7:0] RST_BASE_MAX     = 8'd180;

   // gripper presets and rotation commands
   localparam logic [8:0] GRIP_PRESET_A = 9'd20;
   localparam logic [8:0] GRIP_PRESET_B = 9'd110;
   localparam logic [8:0] GRIP_PRESET_C = 9'd270;
   localparam logic [8:0] GRIP_LIMIT    = 9'd270;
   localparam logic [7:0] SPIN_ZERO     = 8'd0;
   localparam logic [7:0] SPIN_STOP     = 8'd90;
   localparam logic [7:0] SPIN_FULL     = 8'd180;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   typedef struct packed {
      logic [7:0] stick1_x;
      logic [7:0] stick1_y;
      logic [7:0] stick2_y;
      logic       stick1_press;
      logic       stick2_press;
      logic       grip_a;
      logic       grip_b;
      logic       grip_c;
      logic       arm_mode;
      logic       joint_sub;
   } req_type;

   typedef struct packed {
      logic [2:0] drive_dir;
      logic [7:0] duty;
      logic [7:0] base_servo;
      logic [7:0] arm_servo;
      logic [7:0] wrist_servo;
      logic [8:0] grip_angle;
      logic [7:0] spin_cmd;
   } rsp_type;

   typedef struct packed {
      logic [7:0] stick_center;
      logic [6:0] dead_zone;
      logic [4:0] jog_step;
      logic [7:0] duty_limit;
      logic [7:0] arm_min;
      logic [7:0] arm_max;
      logic [7:0] wrist_max;
      logic [7:0] base_max;
   } cfg_type;

endpackage

[sv/joystick_drive_and_joint_jog.sv]
// rsp_valid rises once an accepted request has passed from the input register into the result register
// throughput: one request per cycle unless rsp_ready stalls the output; the joint and drive state is updated in the
//    same single pass that loads the result register, so the next request sees it at once
// reset (synchronous, active high): registers to defaults, angles 0, rotation 90,
//    drive stopped with zero duty, both stages empty
module joystick_drive_and_joint_jog import jdjj_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   req_type req_ff;
   logic    req_valid_ff;
   rsp_type state_ff;
   rsp_type state_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    out_free;
   logic    advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && out_free;
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   jdjj_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (req_ff),
      .nxt (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_center <= RST_STICK_CENTER;
         cfg_ff.dead_zone    <= RST_DEAD_ZONE;
         cfg_ff.jog_step     <= RST_JOG_STEP;
         cfg_ff.duty_limit   <= RST_DUTY_LIMIT;
         cfg_ff.arm_min      <= RST_ARM_MIN;
         cfg_ff.arm_max      <= RST_ARM_MAX;
         cfg_ff.wrist_max    <= RST_WRIST_MAX;
         cfg_ff.base_max     <= RST_BASE_MAX;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_STICK_CENTER: cfg_ff.stick_center <= csr_wdata;
            REG_DEAD_ZONE:    cfg_ff.dead_zone    <= csr_wdata[6:0];
            REG_JOG_STEP:     cfg_ff.jog_step     <= csr_wdata[4:0];
            REG_DUTY_LIMIT:   cfg_ff.duty_limit   <= csr_wdata;
            REG_ARM_MIN:      cfg_ff.arm_min      <= csr_wdata;
            REG_ARM_MAX:      cfg_ff.arm_max      <= csr_wdata;
            REG_WRIST_MAX:    cfg_ff.wrist_max    <= csr_wdata;
            REG_BASE_MAX:     cfg_ff.base_max     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{drive_dir: DIR_STOP, duty: '0, base_servo: '0, arm_servo: '0,
                           wrist_servo: '0, grip_angle: '0, spin_cmd: SPIN_STOP};
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= state_in;
      end
   end

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("request left the input stage but no response appeared");

   a_stop_has_zero_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.drive_dir == DIR_STOP) |-> (rsp_data.duty == '0))
      else $error("stopped drive carries a nonzero duty");

   a_grip_preset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.grip_angle == '0) || (rsp_data.grip_angle == GRIP_PRESET_A) ||
                    (rsp_data.grip_angle == GRIP_PRESET_B) ||
                    (rsp_data.grip_angle == GRIP_PRESET_C))
      else $error("gripper angle is not a preset");

   a_spin_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.spin_cmd == SPIN_ZERO) || (rsp_data.spin_cmd == SPIN_STOP) ||
                    (rsp_data.spin_cmd == SPIN_FULL))
      else $error("rotation command is not 0, 90 or 180");

endmodule

[sv/jdjj_step.sv]
module jdjj_step import jdjj_pkg::*; (
   input  cfg_type cfg,
   input  rsp_type cur,
   input  req_type req,
   output rsp_type nxt
);

   logic signed [10:0] center;
   logic signed [10:0] dz;
   logic signed [10:0] step;
   logic signed [10:0] hi;
   logic signed [10:0] lo;
   logic signed [10:0] x1;
   logic signed [10:0] y1;
   logic signed [10:0] y2;
   logic signed [10:0] diff;
   logic signed [10:0] lim;
   logic signed [10:0] a;
   logic signed [10:0] b;
   logic signed [10:0] w;
   logic [2:0]         dir;

   always_comb begin
      center = $signed({3'b000, cfg.stick_center});
      dz     = $signed({4'b0000, cfg.dead_zone});
      step   = $signed({6'b000000, cfg.jog_step});
      hi     = center + dz;
      lo     = center - dz;
      x1     = $signed({3'b000, req.stick1_x});
      y1     = $signed({3'b000, req.stick1_y});
      y2     = $signed({3'b000, req.stick2_y});
      lim    = $signed({3'b000, cfg.duty_limit});
      a      = $signed({3'b000, cur.arm_servo});
      b      = $signed({3'b000, cur.base_servo});
      w      = $signed({3'b000, cur.wrist_servo});
      dir    = DIR_STOP;
      diff   = '0;
      nxt    = cur;

      if (!req.arm_mode) begin
         // vertical deflection wins over horizontal
         if (y1 > hi) begin
            dir  = DIR_FWD;
            diff = y1 - center + dz;
         end else if (y1 < lo) begin
            dir  = DIR_BACK;
            diff = lo - y1;
         end else if (x1 > hi) begin
            dir  = DIR_LEFT;
            diff = x1 - center + dz;
         end else if (x1 < lo) begin
            dir  = DIR_RIGHT;
            diff = lo - x1;
         end
         nxt.drive_dir = dir;
         nxt.duty      = (diff > lim) ? cfg.duty_limit : diff[7:0];
      end else if (!req.joint_sub) begin
         if (y1 < lo) begin
            a = a - step;
         end else if (y1 > hi) begin
            a = a + step;
         end else if (x1 > hi) begin
            b = b - step;
         end else if (x1 < lo) begin
            b = b + step;
         end else if (y2 > hi) begin
            w = w - step;
         end else if (y2 < lo) begin
            w = w + step;
         end else if (!req.grip_a) begin
            nxt.grip_angle = GRIP_PRESET_A;
         end else if (!req.grip_b) begin
            nxt.grip_angle = GRIP_PRESET_B;
         end else if (!req.grip_c) begin
            nxt.grip_angle = GRIP_PRESET_C;
         end else if (!req.stick1_press && req.stick2_press) begin
            nxt.spin_cmd = SPIN_ZERO;
         end else if (!req.stick2_press && req.stick1_press) begin
            nxt.spin_cmd = SPIN_FULL;
         end else if (req.stick1_press && req.stick2_press) begin
            nxt.spin_cmd = SPIN_STOP;
         end
      end

      // clamps run on every request, whatever the mode
      if (nxt.grip_angle > GRIP_LIMIT) begin
         nxt.grip_angle = '0;
      end

      // upper arm limit checked first, so with crossed limits a value above arm_max ends at arm_max
      if (a > $signed({3'b000, cfg.arm_max})) begin
         nxt.arm_servo = cfg.arm_max;
      end else if (a < $signed({3'b000, cfg.arm_min})) begin
         nxt.arm_servo = cfg.arm_min;
      end else begin
         nxt.arm_servo = a[7:0];
      end

      if (w > $signed({3'b000, cfg.wrist_max})) begin
         nxt.wrist_servo = cfg.wrist_max;
      end else if (w < 0) begin
         nxt.wrist_servo = '0;
      end else begin
         nxt.wrist_servo = w[7:0];
      end

      if (b > $signed({3'b000, cfg.base_max})) begin
         nxt.base_servo = cfg.base_max;
      end else if (b < 0) begin
         nxt.base_servo = '0;
      end else begin
         nxt.base_servo = b[7:0];
      end
   end

endmodule
